[hw/rtl/assert_macros.svh]
// Assertion helpers: clock, active-low reset, antecedent, consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/bclru_pkg.sv]
package bclru_pkg;

  localparam int ACT_W   = 2;
  localparam int BLK_W   = 48;
  localparam int TICK_W  = 64;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 32;
  localparam int ENTRY_W = BLK_W + TICK_W;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam action_t ACT_READ  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_INVAL = 2'd2;

endpackage

[hw/rtl/bclru_req_if.sv]
interface bclru_req_if;
  logic                 valid;
  logic                 ready;
  bclru_pkg::action_t   action;
  bclru_pkg::blk_t      block_number;
  bclru_pkg::tick_t     now_tick;
  logic                 disk_ok;

  modport source (output valid, action, block_number, now_tick, disk_ok, input ready);
  modport sink   (input valid, action, block_number, now_tick, disk_ok, output ready);
endinterface

[hw/rtl/bclru_rsp_if.sv]
interface bclru_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          hit;
  logic [bclru_pkg::SLOT_W-1:0]  slot;
  logic                          slot_valid;
  logic                          replaced_valid;
  bclru_pkg::blk_t               replaced_block;
  bclru_pkg::count_t             hit_count;
  bclru_pkg::count_t             miss_count;
  bclru_pkg::count_t             write_count;

  modport source (output valid, status, hit, slot, slot_valid, replaced_valid,
                  replaced_block, hit_count, miss_count, write_count, input ready);
  modport sink   (input valid, status, hit, slot, slot_valid, replaced_valid,
                  replaced_block, hit_count, miss_count, write_count, output ready);
endinterface

[hw/rtl/bclru_ram.sv]
module bclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/block_cache_lru_tag_controller_unit.sv]
// channel  | dir | handshake       | beat payload
// in_req   | in  | valid / ready   | action, block_number, now_tick, disk_ok
// out_rsp  | out | valid / ready   | status, hit, slot, slot_valid, replaced_valid,
//          |     |                 | replaced_block, hit_count, miss_count, write_count
//
// Each request scans the tag/stamp RAM with one read per cycle for match, first invalid
// slot and oldest stamp, then ends with an update step.
// Reset clears the valid bits and counters at once; the RAM needs no clearing pass.
// A new request is taken while the previous result still waits in the output register;
// the update cycle holds until that register is free.
module block_cache_lru_tag_controller_unit #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  bclru_req_if.sink    in_req,
  bclru_rsp_if.source  out_rsp
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(ENTRIES);
  localparam int EW = (IW > bclru_pkg::SLOT_W) ? IW : bclru_pkg::SLOT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // request
  bclru_pkg::action_t act_r;
  bclru_pkg::blk_t    blk_r;
  bclru_pkg::tick_t   now_r;
  logic               ok_r;

  // scan
  logic [IW:0]      cnt_r;
  logic             dval_r;
  logic [IW-1:0]    didx_r;
  logic             mfound_r;
  logic [IW-1:0]    midx_r;
  logic             ifound_r;
  logic [IW-1:0]    iidx_r;
  logic [IW-1:0]    bidx_r;
  bclru_pkg::tick_t bstamp_r;
  bclru_pkg::blk_t  btag_r;

  logic [ENTRIES-1:0] valid_r;
  bclru_pkg::count_t  hits_r, misses_r, writes_r;
  bclru_pkg::count_t  hits_nxt, misses_nxt, writes_nxt;

  // output register
  logic               ov_r;
  logic               o_status_r, o_hit_r, o_slotv_r, o_repv_r;
  logic [bclru_pkg::SLOT_W-1:0] o_slot_r;
  bclru_pkg::blk_t    o_repblk_r;

  // RAM
  logic                              re_w, we_w;
  logic [IW-1:0]                     waddr_w;
  logic [bclru_pkg::ENTRY_W-1:0]     rdata_w;
  bclru_pkg::blk_t                   rd_tag;
  bclru_pkg::tick_t                  rd_stamp;

  // update decision
  logic             fin_go;
  logic             f_status, f_hit, f_slotv, f_repv, f_set, f_clr;
  logic [IW-1:0]    f_idx;
  bclru_pkg::blk_t  f_repblk;
  logic [EW-1:0]    f_idx_ext;
  logic             is_rd, is_wr;

  assign rd_tag   = rdata_w[bclru_pkg::ENTRY_W-1:bclru_pkg::TICK_W];
  assign rd_stamp = rdata_w[bclru_pkg::TICK_W-1:0];
  assign re_w     = (state_r == ST_SCAN) && (cnt_r < (IW+1)'(ENTRIES));

  bclru_ram #(
    .WIDTH (bclru_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we_w),
    .waddr (waddr_w),
    .wdata ({blk_r, now_r}),
    .re    (re_w),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata_w)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign fin_go       = (state_r == ST_FIN) && (!ov_r || out_rsp.ready);
  assign is_rd        = (act_r == bclru_pkg::ACT_READ);
  assign is_wr        = (act_r == bclru_pkg::ACT_WRITE);

  always_comb begin
    f_status   = 1'b0;
    f_hit      = 1'b0;
    f_slotv    = 1'b0;
    f_repv     = 1'b0;
    f_repblk   = '0;
    f_set      = 1'b0;
    f_clr      = 1'b0;
    f_idx      = '0;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    writes_nxt = writes_r;
    if (is_rd || is_wr) begin
      if (is_wr) begin
        writes_nxt = writes_r + 1'b1;
      end
      if (mfound_r && (!is_wr || ok_r)) begin
        f_hit   = 1'b1;
        f_slotv = 1'b1;
        f_idx   = midx_r;
        f_set   = 1'b1;
        if (is_rd) begin
          hits_nxt = hits_r + 1'b1;
        end
      end else begin
        if (is_rd) begin
          misses_nxt = misses_r + 1'b1;
        end
        if (!ok_r) begin
          f_status = 1'b1;
        end else begin
          f_slotv = 1'b1;
          f_set   = 1'b1;
          if (ifound_r) begin
            f_idx = iidx_r;
          end else begin
            f_idx    = bidx_r;
            f_repv   = 1'b1;
            f_repblk = btag_r;
          end
        end
      end
    end else if (act_r == bclru_pkg::ACT_INVAL) begin
      if (mfound_r) begin
        f_hit   = 1'b1;
        f_slotv = 1'b1;
        f_idx   = midx_r;
        f_clr   = 1'b1;
      end
    end
    f_idx_ext = EW'(f_idx);
  end

  assign we_w    = fin_go && f_set;
  assign waddr_w = f_idx;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_req.valid) state_nxt = ST_SCAN;
      ST_SCAN: if (dval_r && didx_r == IW'(ENTRIES-1)) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      writes_r <= '0;
      ov_r     <= 1'b0;
      dval_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dval_r  <= re_w;
      if (fin_go) begin
        ov_r     <= 1'b1;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        writes_r <= writes_nxt;
        if (f_set) begin
          valid_r[f_idx] <= 1'b1;
        end
        if (f_clr) begin
          valid_r[f_idx] <= 1'b0;
        end
      end else if (out_rsp.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      act_r    <= in_req.action;
      blk_r    <= in_req.block_number;
      now_r    <= in_req.now_tick;
      ok_r     <= in_req.disk_ok;
      cnt_r    <= '0;
      mfound_r <= 1'b0;
      ifound_r <= 1'b0;
    end else if (re_w) begin
      cnt_r <= cnt_r + 1'b1;
    end
    didx_r <= cnt_r[IW-1:0];
    if (dval_r) begin
      if (!mfound_r && valid_r[didx_r] && rd_tag == blk_r) begin
        mfound_r <= 1'b1;
        midx_r   <= didx_r;
      end
      if (!ifound_r && !valid_r[didx_r]) begin
        ifound_r <= 1'b1;
        iidx_r   <= didx_r;
      end
      if (didx_r == '0 || rd_stamp < bstamp_r) begin
        bidx_r   <= didx_r;
        bstamp_r <= rd_stamp;
        btag_r   <= rd_tag;
      end
    end
    if (fin_go) begin
      o_status_r <= f_status;
      o_hit_r    <= f_hit;
      o_slotv_r  <= f_slotv;
      o_slot_r   <= f_idx_ext[bclru_pkg::SLOT_W-1:0];
      o_repv_r   <= f_repv;
      o_repblk_r <= f_repblk;
    end
  end

  assign out_rsp.valid          = ov_r;
  assign out_rsp.status         = o_status_r;
  assign out_rsp.hit            = o_hit_r;
  assign out_rsp.slot           = o_slot_r;
  assign out_rsp.slot_valid     = o_slotv_r;
  assign out_rsp.replaced_valid = o_repv_r;
  assign out_rsp.replaced_block = o_repblk_r;
  assign out_rsp.hit_count      = hits_r;
  assign out_rsp.miss_count     = misses_r;
  assign out_rsp.write_count    = writes_r;

  `ASSERT_IMP(a_ram_wr_fin, clk, rst_n, we_w, state_r == ST_FIN)
  `ASSERT_IMP(a_rd_scan, clk, rst_n, re_w, !in_req.ready)
  `ASSERT_NXT(a_fin_out, clk, rst_n, fin_go, ov_r && state_r == ST_IDLE)
  `ASSERT_IMP(a_err_noslot, clk, rst_n, ov_r && o_status_r, !o_slotv_r && !o_repv_r)

endmodule
